// ===== rtl/core/motor_telemetry_frame_parser_macros.svh =====
// Assertion macros for the motor telemetry frame parser.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MOTOR_TELEMETRY_FRAME_PARSER_MACROS_SVH
`define MOTOR_TELEMETRY_FRAME_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// antecedent in this cycle implies consequent in the same cycle
`define MTFP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mtfp assertion failed");
// antecedent in this cycle implies consequent in the next cycle
`define MTFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mtfp assertion failed");
`else
`define MTFP_ASSERT_SAME(lbl, ante, cons)
`define MTFP_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/mtfp_pkg.sv =====
// Shared types, constants and helpers of the motor telemetry frame parser.
// No dependencies.
package mtfp_pkg;

  localparam int unsigned CountW   = 6;
  localparam logic [CountW-1:0] FrameLen = 6'd47;
  localparam logic [CountW-1:0] CountMax = 6'd63;
  localparam logic [CountW-1:0] Hdr0Ofs  = 6'd2;
  localparam logic [CountW-1:0] Hdr1Ofs  = 6'd3;
  localparam logic [CountW-1:0] EndOfs   = 6'd45;
  localparam logic [7:0] Hdr0Val  = 8'h7c;
  localparam logic [7:0] Hdr1Val  = 8'h8d;
  localparam logic [7:0] EndVal   = 8'h7d;
  localparam logic [8:0] TempBias = 9'd20;

  localparam int unsigned CapDepth = 8;
  localparam int unsigned OutDataW = 96;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_LEN_HDR = 2'd1,
    ST_END     = 2'd2
  } status_e;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } slot_t;

  // frame-end event from the tracker to the decoder
  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [7:0]  ctemp_raw;
    logic [7:0]  mtemp_raw;
    logic [15:0] rpm_word;
    logic [15:0] cur_word;
    logic [15:0] volt_word;
  } frame_evt_t;

  // capture slot for a frame offset
  function automatic slot_t slot_of(input logic [CountW-1:0] ofs);
    slot_t s;
    s.hit = 1'b1;
    unique case (ofs)
      6'd18:   s.idx = 3'd0;
      6'd19:   s.idx = 3'd1;
      6'd23:   s.idx = 3'd2;
      6'd24:   s.idx = 3'd3;
      6'd30:   s.idx = 3'd4;
      6'd31:   s.idx = 3'd5;
      6'd32:   s.idx = 3'd6;
      6'd33:   s.idx = 3'd7;
      default: begin
        s.hit = 1'b0;
        s.idx = 3'd0;
      end
    endcase
    return s;
  endfunction

  // (raw - 20) * 10 as 13-bit two's complement
  function automatic logic signed [12:0] temp_decode(input logic [7:0] raw);
    logic signed [12:0] d;
    d = 13'(signed'({1'b0, raw} - TempBias));
    return 13'((d <<< 3) + (d <<< 1));
  endfunction

endpackage

// ===== rtl/core/motor_telemetry_frame_parser.sv =====
// Top level of the motor telemetry frame parser.
// Depends on mtfp_pkg, mtfp_track, mtfp_decode and the assertion macro header.
//
//  channel   | dir | tdata                               | tlast      | rate
//  s_axis    | in  | rx_byte [7:0]                       | frame_end  | 1 byte/cycle
//  m_axis    | out | status, temps, rpm, current, volt.. | (none)     | 1 per frame
//
// Each byte passes an input register, then tracking/decode logic into the
// result register, which loads when the last byte leaves the input register.
// Throughput is one byte per cycle while no last byte is held back; the 16x16
// power multiply sits in the decode stage ahead of the result register.
// Reset (async, active low) clears count, flags, held values and valids.
// A last byte waits in the input register while an undelivered result blocks
// the result register; other bytes keep flowing.
`include "motor_telemetry_frame_parser_macros.svh"
module motor_telemetry_frame_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [1:0] status, [14:2] ctrl_temp, [27:15] winding_temp,
  // [43:28] speed_rpm, [59:44] motor_current, [75:60] bus_voltage,
  // [91:76] power_out, [95:92] zero
  output logic [95:0] m_axis_tdata_o
);

  mtfp_pkg::frame_evt_t evt;
  logic                 out_free;

  mtfp_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .out_free_i (out_free),
    .evt_o      (evt)
  );

  mtfp_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_i       (evt),
    .out_free_o  (out_free),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

  // a frame result never overwrites one still waiting downstream
  `MTFP_ASSERT_SAME(a_evt_has_room, evt.valid, out_free)
  // every frame-end event from the tracker shows up as a valid result next cycle
  `MTFP_ASSERT_NEXT(a_evt_gives_result, evt.valid, m_axis_tvalid_o)
  // status code 3 is never produced
  `MTFP_ASSERT_SAME(a_status_legal, m_axis_tvalid_o, m_axis_tdata_o[1:0] != 2'd3)

endmodule

// ===== rtl/core/mtfp_track.sv =====
// Input register and per-byte frame tracking: offset count, header and end
// marker checks, byte capture. Depends on mtfp_pkg.
module mtfp_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           in_byte_i,
  input  logic                 in_last_i,
  input  logic                 out_free_i,
  output mtfp_pkg::frame_evt_t evt_o
);

  logic                          in_valid_q;
  logic [7:0]                    in_byte_q;
  logic                          in_last_q;
  logic [mtfp_pkg::CountW-1:0]   count_q, count_d, count_inc;
  logic                          hdr_good_q, hdr_good_d, hdr_base;
  logic                          end_good_q, end_good_d, end_base;
  logic [7:0]                    cap_q [mtfp_pkg::CapDepth];
  logic                          fire;
  logic                          len_ok;
  mtfp_pkg::slot_t               slot;

  assign fire       = in_valid_q && (!in_last_q || out_free_i);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  // flags as they stand after the byte in the input register
  always_comb begin
    hdr_base   = (count_q == '0) ? 1'b0 : hdr_good_q;
    end_base   = (count_q == '0) ? 1'b0 : end_good_q;
    hdr_good_d = hdr_base;
    end_good_d = end_base;
    if (count_q == mtfp_pkg::Hdr0Ofs) begin
      hdr_good_d = (in_byte_q == mtfp_pkg::Hdr0Val);
    end else if (count_q == mtfp_pkg::Hdr1Ofs) begin
      hdr_good_d = hdr_base && (in_byte_q == mtfp_pkg::Hdr1Val);
    end else if (count_q == mtfp_pkg::EndOfs) begin
      end_good_d = (in_byte_q == mtfp_pkg::EndVal);
    end
    count_inc = (count_q == mtfp_pkg::CountMax) ? count_q : count_q + 1'b1;
    count_d   = in_last_q ? '0 : count_inc;
  end

  assign len_ok = (count_inc == mtfp_pkg::FrameLen);
  assign slot   = mtfp_pkg::slot_of(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      hdr_good_q <= 1'b0;
      end_good_q <= 1'b0;
    end else if (fire) begin
      count_q    <= count_d;
      hdr_good_q <= hdr_good_d;
      end_good_q <= end_good_d;
    end
  end

  // capture store: every slot is written before a good frame reads it
  always_ff @(posedge clk_i) begin
    if (fire && slot.hit) begin
      cap_q[slot.idx] <= in_byte_q;
    end
  end

  always_comb begin
    evt_o.valid = fire && in_last_q;
    priority if (!len_ok || !hdr_good_d) begin
      evt_o.status = mtfp_pkg::ST_LEN_HDR;
    end else if (!end_good_d) begin
      evt_o.status = mtfp_pkg::ST_END;
    end else begin
      evt_o.status = mtfp_pkg::ST_OK;
    end
    evt_o.ctemp_raw = cap_q[0];
    evt_o.mtemp_raw = cap_q[1];
    evt_o.rpm_word  = {cap_q[3], cap_q[2]};
    evt_o.cur_word  = {cap_q[5], cap_q[4]};
    evt_o.volt_word = {cap_q[7], cap_q[6]};
  end

endmodule

// ===== rtl/core/mtfp_decode.sv =====
// Telemetry decode, held values and result register.
// Depends on mtfp_pkg.
module mtfp_decode (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtfp_pkg::frame_evt_t              evt_i,
  output logic                              out_free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mtfp_pkg::OutDataW-1:0]     out_data_o
);

  logic                out_valid_q;
  mtfp_pkg::status_e   status_q;
  logic signed [12:0]  ctemp_q, mtemp_q;
  logic [15:0]         rpm_q, cur_q, volt_q, pwr_q;
  logic [31:0]         prod;
  logic [18:0]         rpm_x10;
  logic                take;

  assign out_free_o = !out_valid_q || out_ready_i;
  assign take       = evt_i.valid && evt_i.status == mtfp_pkg::ST_OK;
  assign prod       = evt_i.cur_word * evt_i.volt_word;
  assign rpm_x10    = ({3'd0, evt_i.rpm_word} << 3) + ({3'd0, evt_i.rpm_word} << 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= mtfp_pkg::ST_OK;
      ctemp_q     <= '0;
      mtemp_q     <= '0;
      rpm_q       <= '0;
      cur_q       <= '0;
      volt_q      <= '0;
      pwr_q       <= '0;
    end else begin
      if (evt_i.valid) begin
        out_valid_q <= 1'b1;
        status_q    <= evt_i.status;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (take) begin
        ctemp_q <= mtfp_pkg::temp_decode(evt_i.ctemp_raw);
        mtemp_q <= mtfp_pkg::temp_decode(evt_i.mtemp_raw);
        rpm_q   <= rpm_x10[15:0];
        cur_q   <= evt_i.cur_word;
        volt_q  <= evt_i.volt_word;
        pwr_q   <= prod[15:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {4'd0, pwr_q, volt_q, cur_q, rpm_q, mtemp_q, ctemp_q, status_q};

endmodule

// ===== tb/motor_telemetry_frame_parser_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for motor_telemetry_frame_parser: streams reply frames
// byte by byte, predicts the reply of every frame and checks each m_axis transaction.
// Depends on mtfp_pkg and the parser RTL only.
module motor_telemetry_frame_parser_test;

  // Frame offsets of the decoded fields (low byte of each word).
  localparam int unsigned CtempOfs = 18;
  localparam int unsigned MtempOfs = 19;
  localparam int unsigned RpmOfs   = 23;
  localparam int unsigned CurOfs   = 30;
  localparam int unsigned VoltOfs  = 32;
  localparam int DecodeScale = 10;

  localparam int IdleLimit   = 2000;  // cycles with no transaction on either side
  localparam int RandomBytes = 1350;
  localparam int MinReplies  = 24;
  localparam int MaxReport   = 10;
  localparam int DrainCycles = 8;     // input reg + decode stage, with margin

  // Same layout as m_axis_tdata_o, lowest field last.
  typedef struct packed {
    logic [3:0]         pad;
    logic signed [15:0] power;
    logic signed [15:0] volt;
    logic signed [15:0] cur;
    logic signed [15:0] rpm;
    logic signed [12:0] mtemp;
    logic signed [12:0] ctemp;
    mtfp_pkg::status_e  status;
  } telemetry_t;

  typedef logic [7:0] byte_q_t[$];

  // Tracks the frame as the parser sees it and queues the reply each frame_end
  // should produce; compares replies in order.
  class telemetry_checker;
    logic [5:0]  byte_cnt;
    logic        hdr_ok;
    logic        end_ok;
    logic [7:0]  ctemp_raw;
    logic [7:0]  mtemp_raw;
    logic [15:0] rpm_word;
    logic [15:0] cur_word;
    logic [15:0] volt_word;
    telemetry_t  held;
    telemetry_t  expected_replies[$];
    int unsigned mismatches;
    int unsigned replies;
    int unsigned n_ok;
    int unsigned n_len_hdr;
    int unsigned n_end;

    function new();
      byte_cnt   = '0;
      hdr_ok     = 1'b0;
      end_ok     = 1'b0;
      ctemp_raw  = '0;
      mtemp_raw  = '0;
      rpm_word   = '0;
      cur_word   = '0;
      volt_word  = '0;
      held       = '0;
      mismatches = 0;
      replies    = 0;
      n_ok       = 0;
      n_len_hdr  = 0;
      n_end      = 0;
    endfunction

    function string show(telemetry_t r);
      return $sformatf("status=%0d ctemp=%0d mtemp=%0d rpm=%0d cur=%0d volt=%0d power=%0d pad=%h",
                       r.status, r.ctemp, r.mtemp, r.rpm, r.cur, r.volt, r.power, r.pad);
    endfunction

    function void take_byte(logic [7:0] b, logic last);
      int          t;
      logic [31:0] p;
      telemetry_t  r;
      if (byte_cnt == 0) begin
        hdr_ok = 1'b0;
        end_ok = 1'b0;
      end
      if (byte_cnt == mtfp_pkg::Hdr0Ofs) hdr_ok = (b == mtfp_pkg::Hdr0Val);
      else if (byte_cnt == mtfp_pkg::Hdr1Ofs) hdr_ok = hdr_ok && (b == mtfp_pkg::Hdr1Val);
      else if (byte_cnt == mtfp_pkg::EndOfs) end_ok = (b == mtfp_pkg::EndVal);
      case (int'(byte_cnt))
        CtempOfs:    ctemp_raw = b;
        MtempOfs:    mtemp_raw = b;
        RpmOfs:      rpm_word[7:0] = b;
        RpmOfs + 1:  rpm_word[15:8] = b;
        CurOfs:      cur_word[7:0] = b;
        CurOfs + 1:  cur_word[15:8] = b;
        VoltOfs:     volt_word[7:0] = b;
        VoltOfs + 1: volt_word[15:8] = b;
        default: ;
      endcase
      if (byte_cnt != mtfp_pkg::CountMax) byte_cnt++;
      if (!last) return;

      // length/header error wins over a bad end marker
      r = held;
      if (byte_cnt != mtfp_pkg::FrameLen || !hdr_ok) begin
        r.status = mtfp_pkg::ST_LEN_HDR;
        n_len_hdr++;
      end else if (!end_ok) begin
        r.status = mtfp_pkg::ST_END;
        n_end++;
      end else begin
        t = (int'(ctemp_raw) - int'(mtfp_pkg::TempBias)) * DecodeScale;
        held.ctemp = t[12:0];
        t = (int'(mtemp_raw) - int'(mtfp_pkg::TempBias)) * DecodeScale;
        held.mtemp = t[12:0];
        t = int'(rpm_word) * DecodeScale;
        held.rpm = t[15:0];
        held.cur = cur_word;
        held.volt = volt_word;
        p = 32'(cur_word) * 32'(volt_word);
        held.power = p[15:0];
        held.status = mtfp_pkg::ST_OK;
        r = held;
        n_ok++;
      end
      expected_replies.push_back(r);
      byte_cnt = '0;
    endfunction

    function void check_reply(logic [95:0] d);
      telemetry_t got;
      telemetry_t want;
      got = telemetry_t'(d);
      replies++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReport)
          $display("reply %0d with no frame pending: %s", replies, show(got));
        return;
      end
      want = expected_replies.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReport) begin
          $display("reply %0d mismatch", replies);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = '0;   // [7:0] rx_byte
  logic        s_axis_tlast_i = 1'b0; // frame_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [1:0] status, [14:2] ctrl_temp, [27:15] winding_temp, [43:28] speed_rpm,
  // [59:44] motor_current, [75:60] bus_voltage, [91:76] power_out, [95:92] zero
  logic [95:0] m_axis_tdata_o;

  telemetry_checker tm_check = new();
  int unsigned bytes_in = 0;
  int unsigned idle_cycles = 0;

  motor_telemetry_frame_parser i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Monitors sample at the edge; inputs change only via NBA, so the values
  // seen here are the ones the parser sampled.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      tm_check.take_byte(s_axis_tdata_i, s_axis_tlast_i);
      bytes_in++;
    end
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tm_check.check_reply(m_axis_tdata_o);
  end

  // Watchdog: any transaction resets the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Reply side: random stall before each reply, with calm stretches of none.
  initial begin
    bit calm;
    int stall;
    calm = 1'b0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  function automatic int draw_gap();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
  endfunction

  // Random bytes with header and end marker in place, then optionally broken.
  function automatic byte_q_t make_frame(int len, bit good_hdr, bit good_end);
    byte_q_t fr;
    for (int i = 0; i < len; i++) fr.push_back(8'($urandom));
    if (len > mtfp_pkg::Hdr1Ofs) begin
      fr[mtfp_pkg::Hdr0Ofs] = mtfp_pkg::Hdr0Val;
      fr[mtfp_pkg::Hdr1Ofs] = mtfp_pkg::Hdr1Val;
      if (!good_hdr)
        fr[mtfp_pkg::Hdr0Ofs + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end
    if (len > mtfp_pkg::EndOfs)
      fr[mtfp_pkg::EndOfs] = good_end ? mtfp_pkg::EndVal
                                      : mtfp_pkg::EndVal ^ 8'($urandom_range(1, 255));
    return fr;
  endfunction

  // One transaction; returns at the edge where it was accepted, valid still high.
  task automatic send_byte(input logic [7:0] b, input logic last, input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input byte_q_t fr, input bit steady);
    foreach (fr[i])
      send_byte(fr[i], i == fr.size() - 1, steady ? 0 : draw_gap());
  endtask

  task automatic send_good(input logic [7:0] ct, input logic [7:0] mt,
                           input logic [15:0] rpm, input logic [15:0] cur,
                           input logic [15:0] volt, input bit steady);
    byte_q_t fr;
    fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b1);
    fr[CtempOfs]    = ct;
    fr[MtempOfs]    = mt;
    fr[RpmOfs]      = rpm[7:0];
    fr[RpmOfs + 1]  = rpm[15:8];
    fr[CurOfs]      = cur[7:0];
    fr[CurOfs + 1]  = cur[15:8];
    fr[VoltOfs]     = volt[7:0];
    fr[VoltOfs + 1] = volt[15:8];
    send_frame(fr, steady);
  endtask

  // Sender holds off until every pending reply has been delivered. The first
  // edge lets the monitor log a last byte taken in this same time step.
  task automatic drain_replies();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (tm_check.expected_replies.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    byte_q_t     fr;
    int          kind;
    int          len;
    int unsigned rnd_bytes;
    int unsigned rnd_frames;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: error before any good frame gives the reset values back
    send_frame(make_frame(1, 1'b1, 1'b1), 1'b0);
    // temperature, rpm, current and voltage extremes
    send_good(8'h00, 8'hff, 16'hffff, 16'h8000, 16'h7fff, 1'b0);
    send_good(8'hff, 8'h00, 16'h0000, 16'h7fff, 16'h8000, 1'b1);
    send_good(8'd20, 8'd20, 16'h0ccc, 16'hffff, 16'hffff, 1'b1);
    // header byte wrong at each position, then swapped
    fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b1);
    fr[mtfp_pkg::Hdr0Ofs] = 8'h00;
    send_frame(fr, 1'b0);
    fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b1);
    fr[mtfp_pkg::Hdr1Ofs] = 8'hff;
    send_frame(fr, 1'b0);
    fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b1);
    fr[mtfp_pkg::Hdr0Ofs] = mtfp_pkg::Hdr1Val;
    fr[mtfp_pkg::Hdr1Ofs] = mtfp_pkg::Hdr0Val;
    send_frame(fr, 1'b0);
    // bad end marker alone, then together with a bad header (header wins)
    send_frame(make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b0), 1'b0);
    send_frame(make_frame(mtfp_pkg::FrameLen, 1'b0, 1'b0), 1'b0);
    // short, long and saturating lengths with correct markers
    send_frame(make_frame(mtfp_pkg::FrameLen - 1, 1'b1, 1'b1), 1'b0);
    send_frame(make_frame(mtfp_pkg::FrameLen + 1, 1'b1, 1'b1), 1'b0);
    send_frame(make_frame(mtfp_pkg::CountMax, 1'b1, 1'b1), 1'b0);
    send_frame(make_frame(70, 1'b1, 1'b1), 1'b0);
    send_frame(make_frame(4, 1'b1, 1'b1), 1'b0);
    // single-byte frames back to back press on the result register
    for (int i = 0; i < 4; i++) send_frame(make_frame(1, 1'b1, 1'b1), 1'b1);
    send_good(8'd123, 8'd45, 16'h1234, 16'hfffe, 16'h0003, 1'b1);
    drain_replies();

    // Random: mostly well-formed frames with random content
    rnd_bytes  = 0;
    rnd_frames = 0;
    while (rnd_bytes < RandomBytes || rnd_frames < MinReplies) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b1);
      end else if (kind == 7) begin
        fr = make_frame(mtfp_pkg::FrameLen, 1'b0, $urandom_range(0, 1));
      end else if (kind == 8) begin
        fr = make_frame(mtfp_pkg::FrameLen, 1'b1, 1'b0);
      end else begin
        len = $urandom_range(0, 1) ? $urandom_range(44, 50) : $urandom_range(1, 70);
        fr = make_frame(len, $urandom_range(0, 1), $urandom_range(0, 1));
      end
      send_frame(fr, $urandom_range(0, 4) == 0);
      rnd_bytes += fr.size();
      rnd_frames++;
      if ($urandom_range(0, 11) == 0) drain_replies();
    end

    drain_replies();
    repeat (DrainCycles) @(posedge clk_i);

    $display("run: %0d bytes, %0d replies (%0d decoded, %0d length/header, %0d end marker)",
             bytes_in, tm_check.replies, tm_check.n_ok, tm_check.n_len_hdr, tm_check.n_end);
    $display("run: %0d mismatches, %0d replies still pending",
             tm_check.mismatches, tm_check.expected_replies.size());
    if (tm_check.mismatches == 0 && tm_check.expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== motor_telemetry_frame_parser.f =====
+incdir+rtl/core
rtl/core/mtfp_pkg.sv
rtl/core/mtfp_track.sv
rtl/core/mtfp_decode.sv
rtl/core/motor_telemetry_frame_parser.sv
tb/motor_telemetry_frame_parser_test.sv
